### rtl/core/sedf_pkg.sv
// Shared types and constants for the STX/ETX/DLE frame decoder.
package sedf_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned REG_IDX_W = 2;

	// Register indexes on the configuration port (word address bits).
	localparam logic [REG_IDX_W-1:0] REG_START  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_END    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ESCAPE = 2'd2;

	// Reset values of the codes.
	localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'h02;
	localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'h03;
	localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'h10;

	// Frame status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_CHECK = 2'd2;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Operations handed from the classifier to the executor.
	typedef enum logic [2:0] {
		OP_OPEN  = 3'd0, // first byte of a frame, carries the bad-start flag
		OP_STUFF = 3'd1, // escape byte: folded into the check, no output
		OP_CLOSE = 3'd2, // end code: folded into the check, no output
		OP_DATA  = 3'd3, // payload byte: folded into the check and emitted
		OP_CHECK = 3'd4  // check byte: compared and frame status emitted
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
		logic              bad_start;
	} op_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] end_code;
		logic [BYTE_W-1:0] escape_code;
	} codes_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

endpackage

### rtl/core/sedf_front.sv
// Front part: tracks framing and escapes and classifies each received byte.
module sedf_front
	import sedf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [BYTE_W-1:0] rx_byte,
	input  codes_t            codes,
	output op_item_t          item
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_DATA  = 3'b010,
		PH_CHECK = 3'b100
	} phase_t;

	phase_t phase_q, phase_d;
	logic   escape_q, escape_d;

	always_comb begin
		phase_d        = phase_q;
		escape_d       = escape_q;
		item.op        = OP_OPEN;
		item.data      = rx_byte;
		item.bad_start = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				item.op        = OP_OPEN;
				item.bad_start = (rx_byte != codes.start_code);
				escape_d       = 1'b0;
				phase_d        = PH_DATA;
			end
			PH_DATA: begin
				// The escape test comes before the end test.
				priority if (escape_q) begin
					item.op  = OP_DATA;
					escape_d = 1'b0;
				end else if (rx_byte == codes.escape_code) begin
					item.op  = OP_STUFF;
					escape_d = 1'b1;
				end else if (rx_byte == codes.end_code) begin
					item.op = OP_CLOSE;
					phase_d = PH_CHECK;
				end else begin
					item.op = OP_DATA;
				end
			end
			PH_CHECK: begin
				item.op = OP_CHECK;
				escape_d = 1'b0;
				phase_d = PH_IDLE;
			end
			default: begin
				item.op = OP_OPEN;
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			escape_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			escape_q <= escape_d;
		end
	end

endmodule

### rtl/core/sedf_queue.sv
// Short FIFO of classified operations between the front and back parts.
module sedf_queue
	import sedf_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  op_item_t      push_item,
	input  logic          pop,
	output op_item_t      head,
	output queue_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	op_item_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full      = (count_q == FULL_CNT);
	assign status.not_empty = (count_q != '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && status.not_empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/sedf_back.sv
// Back part: runs the XOR check, builds results and holds the output register.
module sedf_back
	import sedf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  op_item_t            head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [BYTE_W-1:0]   payload_value,
	output logic [STATUS_W-1:0] frame_status
);

	logic [BYTE_W-1:0]   xor_q;
	logic                seen_q;
	logic                missing_q;
	logic                out_valid_q;
	logic                kind_q;
	logic [BYTE_W-1:0]   value_q;
	logic [STATUS_W-1:0] status_q;

	logic                emits;
	logic                slot_free;
	logic [BYTE_W-1:0]   expect_check;
	logic [STATUS_W-1:0] status_d;

	assign emits     = (head.op == OP_DATA) || (head.op == OP_CHECK);
	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = head_valid && (!emits || slot_free);

	assign expect_check = seen_q ? xor_q : '0;

	always_comb begin
		priority if (missing_q) begin
			status_d = ST_BAD_START;
		end else if (expect_check != head.data) begin
			status_d = ST_BAD_CHECK;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q       <= '0;
			seen_q      <= 1'b0;
			missing_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head.op)
					OP_OPEN: begin
						xor_q     <= '0;
						seen_q    <= 1'b0;
						missing_q <= head.bad_start;
					end
					OP_STUFF: begin
						xor_q  <= xor_q ^ head.data;
						seen_q <= 1'b1;
					end
					OP_CLOSE: begin
						xor_q <= xor_q ^ head.data;
					end
					OP_DATA: begin
						xor_q  <= xor_q ^ head.data;
						seen_q <= 1'b1;
					end
					OP_CHECK: begin
						xor_q     <= '0;
						seen_q    <= 1'b0;
						missing_q <= 1'b0;
					end
					default: begin
						xor_q <= xor_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			if (head.op == OP_CHECK) begin
				kind_q   <= KIND_STATUS;
				value_q  <= '0;
				status_q <= status_d;
			end else begin
				kind_q   <= KIND_PAYLOAD;
				value_q  <= head.data;
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign payload_value = value_q;
	assign frame_status  = status_q;

endmodule

### rtl/core/stx_etx_dle_frame_decoder.sv
// Top level of the STX/ETX/DLE byte-stuffed frame decoder with XOR check.
//
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   rx_byte
//  output    out        out_valid / out_stall result_kind, payload_value, frame_status
//  config    in         APB write/read        start_code, end_code, escape_code
//
// One raw byte can be accepted every cycle. A byte is classified in the cycle
// of its transaction and its operation lands in a two-entry queue; the back
// part drains one operation per cycle while the output register can take it,
// so a payload byte or a frame status reaches the output register only after
// its operation has passed through the queue. The input stalls only when the
// queue is full, which can happen when the output side stalls. After reset
// the codes hold STX, ETX and DLE and the decoder waits for the first byte of
// a frame.
module stx_etx_dle_frame_decoder
	import sedf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	// Received byte stream.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	// Decoded results.
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [7:0]          payload_value,
	output logic [1:0]          frame_status,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	codes_t        codes_q;
	logic          cfg_write;
	logic [REG_IDX_W-1:0] reg_idx;

	logic          take;
	op_item_t      front_item;
	op_item_t      head;
	queue_status_t q_status;
	logic          pop;

	// Configuration registers. Writes must be made only while the decoder is
	// idle (not enforced); they take effect directly on the front part's comparisons.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.start_code  <= START_CODE_RST;
			codes_q.end_code    <= END_CODE_RST;
			codes_q.escape_code <= ESCAPE_CODE_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_START:  codes_q.start_code  <= pwdata[7:0];
				REG_END:    codes_q.end_code    <= pwdata[7:0];
				REG_ESCAPE: codes_q.escape_code <= pwdata[7:0];
				default:    codes_q             <= codes_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START:  prdata = {24'd0, codes_q.start_code};
			REG_END:    prdata = {24'd0, codes_q.end_code};
			REG_ESCAPE: prdata = {24'd0, codes_q.escape_code};
			default:    prdata = '0;
		endcase
	end

	// A transaction on the input is taken whenever the queue has room.
	assign in_stall = q_status.full;
	assign take     = in_valid && !in_stall;

	sedf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.codes   (codes_q),
		.item    (front_item)
	);

	sedf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_item (front_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	sedf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (q_status.not_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.payload_value (payload_value),
		.frame_status  (frame_status)
	);

endmodule
